// ===== rtl/scc_pkg.sv =====
// Shared constants, codes and helpers for the strongly connected components block.
// No dependencies; imported by scc_graph, scc_ctrl and strongly_connected_components.
package scc_pkg;

	// field widths fixed by the item format
	localparam int NODE_W = 6;
	localparam int TIME_W = 7;
	localparam int CNT_W  = 7;
	localparam int COMP_W = 6;

	// default sizes
	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 256;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

	// operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	function automatic logic [TIME_W-1:0] time_min(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

// ===== rtl/scc_graph.sv =====
// Graph store: per-node list heads with valid bits, and the edge memory (target, link).
// Depends on scc_pkg. Read data comes back in the cycle after the request.
module scc_graph #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear_en,
	input  logic                                   head_rd_en,
	input  logic [scc_pkg::NODE_W-1:0]             head_addr,
	output logic [$clog2(MAX_EDGES+1)-1:0]         head_ptr,
	input  logic                                   add_en,
	input  logic [scc_pkg::NODE_W-1:0]             add_src,
	input  logic [scc_pkg::NODE_W-1:0]             add_dst,
	input  logic                                   edge_rd_en,
	input  logic [$clog2(MAX_EDGES)-1:0]           edge_addr,
	output logic [scc_pkg::NODE_W-1:0]             edge_tgt,
	output logic [$clog2(MAX_EDGES+1)-1:0]         edge_link,
	output logic                                   full
);
	import scc_pkg::*;

	localparam int NIW = $clog2(MAX_NODES);
	localparam int AW  = $clog2(MAX_EDGES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam logic [EW-1:0] NULL_PTR = EW'(MAX_EDGES);

	logic [AW-1:0]          head_mem [MAX_NODES];
	logic [MAX_NODES-1:0]   head_vld_q;
	logic [AW-1:0]          head_rd_q;
	logic                   head_hit_q;
	logic [NODE_W+EW-1:0]   edge_mem [MAX_EDGES];
	logic [NODE_W+EW-1:0]   edge_rd_q;
	logic [EW-1:0]          total_q;

	assign full      = (total_q == EW'(MAX_EDGES));
	assign head_ptr  = head_hit_q ? EW'(head_rd_q) : NULL_PTR;
	assign edge_tgt  = edge_rd_q[NODE_W+EW-1:EW];
	assign edge_link = edge_rd_q[EW-1:0];

	// head valid bits and edge count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			total_q    <= '0;
		end else if (clear_en) begin
			head_vld_q <= '0;
			total_q    <= '0;
		end else if (add_en) begin
			head_vld_q[add_src[NIW-1:0]] <= 1'b1;
			total_q <= total_q + EW'(1);
		end
	end

	// head memory
	always_ff @(posedge clk) begin
		if (add_en)
			head_mem[add_src[NIW-1:0]] <= total_q[AW-1:0];
		if (head_rd_en) begin
			head_rd_q  <= head_mem[head_addr[NIW-1:0]];
			head_hit_q <= head_vld_q[head_addr[NIW-1:0]];
		end
	end

	// edge memory: new edge links to the previous head (read the cycle before)
	always_ff @(posedge clk) begin
		if (add_en)
			edge_mem[total_q[AW-1:0]] <= {add_dst, head_ptr};
		if (edge_rd_en)
			edge_rd_q <= edge_mem[edge_addr];
	end

endmodule

// ===== rtl/scc_ctrl.sv =====
// Sequencer for edge adds, clears and the Tarjan search, with the node, stack and
// frame memories and the output register. Depends on scc_pkg; drives scc_graph.
module scc_ctrl #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [scc_pkg::CNT_W-1:0]              n_active,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             operation,
	input  logic [scc_pkg::NODE_W-1:0]             src_node,
	input  logic [scc_pkg::NODE_W-1:0]             dst_node,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [scc_pkg::NODE_W-1:0]             node_id,
	output logic [scc_pkg::COMP_W-1:0]             component_index,
	output logic                                   last_of_component,
	output logic                                   last_of_run,
	output logic [1:0]                             status,
	output logic                                   clear_en,
	output logic                                   head_rd_en,
	output logic [scc_pkg::NODE_W-1:0]             head_addr,
	input  logic [$clog2(MAX_EDGES+1)-1:0]         head_ptr,
	output logic                                   add_en,
	output logic [scc_pkg::NODE_W-1:0]             add_src,
	output logic [scc_pkg::NODE_W-1:0]             add_dst,
	output logic                                   edge_rd_en,
	output logic [$clog2(MAX_EDGES)-1:0]           edge_addr,
	input  logic [scc_pkg::NODE_W-1:0]             edge_tgt,
	input  logic [$clog2(MAX_EDGES+1)-1:0]         edge_link,
	input  logic                                   full
);
	import scc_pkg::*;

	localparam int NIW = $clog2(MAX_NODES);
	localparam int AW  = $clog2(MAX_EDGES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int FW  = NODE_W + EW + 2 * TIME_W;
	localparam logic [EW-1:0] NULL_PTR = EW'(MAX_EDGES);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_WR, S_EMIT1, S_ROOT, S_VIS, S_VIS_HEAD, S_STEP,
		S_EDGE_GOT, S_DISC_GOT, S_POP_RD, S_POP_GOT, S_RET, S_RET_GOT
	} state_t;

	state_t               state_q;
	logic [NODE_W-1:0]    src_q, dst_q;
	logic [1:0]           st1_q;
	logic [CNT_W-1:0]     root_q, clock_q, sp_q, depth_q, emit_cnt_q;
	logic [COMP_W-1:0]    comp_q;
	logic [NODE_W-1:0]    vis_q;
	logic [NODE_W-1:0]    top_node_q;
	logic [EW-1:0]        top_cur_q;
	logic [TIME_W-1:0]    top_low_q, top_disc_q;
	logic [MAX_NODES-1:0] visited_q, onstk_q;

	logic                 out_valid_q, lastc_q, lastr_q;
	logic [NODE_W-1:0]    node_q;
	logic [COMP_W-1:0]    compo_q;
	logic [1:0]           status_q;

	// memories
	logic [TIME_W-1:0]    disc_mem [MAX_NODES];
	logic [NODE_W-1:0]    cstk_mem [MAX_NODES];
	logic [FW-1:0]        frame_mem [MAX_NODES];
	logic [TIME_W-1:0]    disc_rd_q;
	logic [NODE_W-1:0]    cstk_rd_q;
	logic [FW-1:0]        frame_rd_q;

	logic                 disc_we, disc_re, cstk_we, cstk_re, frm_we, frm_re;
	logic [NIW-1:0]       disc_wa, disc_ra, cstk_wa, cstk_ra, frm_wa, frm_ra;
	logic [TIME_W-1:0]    disc_wd;
	logic [FW-1:0]        frm_wd;

	logic                 in_xfer, out_free, out_load, src_bad, dst_bad, tgt_bad, closes;
	logic [CNT_W-1:0]     dm1, dm2, spm1;

	assign in_ready   = (state_q == S_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_load   = out_free && (state_q == S_EMIT1 || state_q == S_POP_GOT);
	assign src_bad    = ({1'b0, src_node} >= n_active);
	assign dst_bad    = ({1'b0, dst_node} >= n_active);
	assign tgt_bad    = ({1'b0, edge_tgt} >= n_active);
	assign closes     = (cstk_rd_q == top_node_q);
	assign dm1        = depth_q - CNT_W'(1);
	assign dm2        = depth_q - CNT_W'(2);
	assign spm1       = sp_q - CNT_W'(1);

	assign out_valid         = out_valid_q;
	assign node_id           = node_q;
	assign component_index   = compo_q;
	assign last_of_component = lastc_q;
	assign last_of_run       = lastr_q;
	assign status            = status_q;

	assign add_src = src_q;
	assign add_dst = dst_q;

	// memory and graph-store strobes per state
	always_comb begin
		clear_en   = 1'b0;
		head_rd_en = 1'b0;
		head_addr  = vis_q;
		add_en     = 1'b0;
		edge_rd_en = 1'b0;
		edge_addr  = top_cur_q[AW-1:0];
		disc_we    = 1'b0;
		disc_wa    = vis_q[NIW-1:0];
		disc_wd    = clock_q + TIME_W'(1);
		disc_re    = 1'b0;
		disc_ra    = edge_tgt[NIW-1:0];
		cstk_we    = 1'b0;
		cstk_wa    = sp_q[NIW-1:0];
		cstk_re    = 1'b0;
		cstk_ra    = spm1[NIW-1:0];
		frm_we     = 1'b0;
		frm_wa     = dm1[NIW-1:0];
		frm_wd     = {top_node_q, top_cur_q, top_low_q, top_disc_q};
		frm_re     = 1'b0;
		frm_ra     = dm2[NIW-1:0];
		case (state_q)
			S_IDLE: begin
				head_addr  = src_node;
				head_rd_en = in_xfer && (operation == OP_ADD);
				clear_en   = in_xfer && (operation == OP_CLEAR);
			end
			S_ADD_WR: add_en = 1'b1;
			S_VIS: begin
				disc_we    = 1'b1;
				cstk_we    = 1'b1;
				frm_we     = (depth_q != '0);
				head_rd_en = 1'b1;
			end
			S_STEP:     edge_rd_en = (top_cur_q != NULL_PTR);
			S_EDGE_GOT: disc_re = !tgt_bad && visited_q[edge_tgt[NIW-1:0]]
				&& onstk_q[edge_tgt[NIW-1:0]];
			S_POP_RD:   cstk_re = 1'b1;
			S_RET:      frm_re = (depth_q > CNT_W'(1));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (disc_we)
			disc_mem[disc_wa] <= disc_wd;
		if (disc_re)
			disc_rd_q <= disc_mem[disc_ra];
	end

	always_ff @(posedge clk) begin
		if (cstk_we)
			cstk_mem[cstk_wa] <= vis_q;
		if (cstk_re)
			cstk_rd_q <= cstk_mem[cstk_ra];
	end

	always_ff @(posedge clk) begin
		if (frm_we)
			frame_mem[frm_wa] <= frm_wd;
		if (frm_re)
			frame_rd_q <= frame_mem[frm_ra];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_q      <= '0;
			clock_q     <= '0;
			sp_q        <= '0;
			depth_q     <= '0;
			emit_cnt_q  <= '0;
			comp_q      <= '0;
			visited_q   <= '0;
			onstk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						src_q <= src_node;
						dst_q <= dst_node;
						case (operation)
							OP_ADD: begin
								if (src_bad || dst_bad) begin
									st1_q   <= ST_RANGE;
									state_q <= S_EMIT1;
								end else if (full) begin
									st1_q   <= ST_FULL;
									state_q <= S_EMIT1;
								end else begin
									st1_q   <= ST_OK;
									state_q <= S_ADD_WR;
								end
							end
							OP_CLEAR: begin
								st1_q   <= ST_OK;
								state_q <= S_EMIT1;
							end
							OP_RUN: begin
								visited_q  <= '0;
								onstk_q    <= '0;
								root_q     <= '0;
								clock_q    <= '0;
								sp_q       <= '0;
								depth_q    <= '0;
								comp_q     <= '0;
								emit_cnt_q <= '0;
								state_q    <= S_ROOT;
							end
							default: ;
						endcase
					end
				end
				S_ADD_WR: state_q <= S_EMIT1;
				S_EMIT1: begin
					if (out_free) begin
						node_q      <= '0;
						compo_q     <= '0;
						lastc_q     <= 1'b0;
						lastr_q     <= 1'b1;
						status_q    <= st1_q;
						state_q     <= S_IDLE;
					end
				end
				S_ROOT: begin
					if (root_q == n_active) begin
						state_q <= S_IDLE;
					end else if (visited_q[root_q[NIW-1:0]]) begin
						root_q <= root_q + CNT_W'(1);
					end else begin
						vis_q   <= root_q[NODE_W-1:0];
						state_q <= S_VIS;
					end
				end
				S_VIS: begin
					clock_q <= clock_q + CNT_W'(1);
					sp_q    <= sp_q + CNT_W'(1);
					visited_q[vis_q[NIW-1:0]] <= 1'b1;
					onstk_q[vis_q[NIW-1:0]]   <= 1'b1;
					state_q <= S_VIS_HEAD;
				end
				S_VIS_HEAD: begin
					top_node_q <= vis_q;
					top_cur_q  <= head_ptr;
					top_low_q  <= clock_q;
					top_disc_q <= clock_q;
					depth_q    <= depth_q + CNT_W'(1);
					state_q    <= S_STEP;
				end
				S_STEP: begin
					if (top_cur_q != NULL_PTR)
						state_q <= S_EDGE_GOT;
					else if (top_low_q == top_disc_q)
						state_q <= S_POP_RD;
					else
						state_q <= S_RET;
				end
				S_EDGE_GOT: begin
					top_cur_q <= edge_link;
					if (tgt_bad) begin
						state_q <= S_STEP;
					end else if (!visited_q[edge_tgt[NIW-1:0]]) begin
						vis_q   <= edge_tgt;
						state_q <= S_VIS;
					end else if (onstk_q[edge_tgt[NIW-1:0]]) begin
						state_q <= S_DISC_GOT;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DISC_GOT: begin
					top_low_q <= time_min(top_low_q, disc_rd_q);
					state_q   <= S_STEP;
				end
				S_POP_RD: begin
					sp_q    <= spm1;
					state_q <= S_POP_GOT;
				end
				S_POP_GOT: begin
					if (out_free) begin
						onstk_q[cstk_rd_q[NIW-1:0]] <= 1'b0;
						node_q      <= cstk_rd_q;
						compo_q     <= comp_q;
						lastc_q     <= closes;
						lastr_q     <= (emit_cnt_q == n_active - CNT_W'(1));
						status_q    <= ST_OK;
						emit_cnt_q  <= emit_cnt_q + CNT_W'(1);
						if (closes) begin
							comp_q  <= comp_q + COMP_W'(1);
							state_q <= S_RET;
						end else begin
							state_q <= S_POP_RD;
						end
					end
				end
				S_RET: begin
					depth_q <= dm1;
					if (depth_q > CNT_W'(1)) begin
						state_q <= S_RET_GOT;
					end else begin
						root_q  <= root_q + CNT_W'(1);
						state_q <= S_ROOT;
					end
				end
				S_RET_GOT: begin
					top_node_q <= frame_rd_q[FW-1 -: NODE_W];
					top_cur_q  <= frame_rd_q[2*TIME_W +: EW];
					top_low_q  <= time_min(frame_rd_q[TIME_W +: TIME_W], top_low_q);
					top_disc_q <= frame_rd_q[TIME_W-1:0];
					state_q    <= S_STEP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the component stack never holds more than every node once
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CNT_W'(MAX_NODES))
		else $error("component stack overflow");

	// open frames sit on the component stack, bar the one whose component was just popped
	a_depth_le_sp: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= sp_q + CNT_W'(1))
		else $error("frame depth exceeds component stack");

	// a finished search leaves no open frame
	a_idle_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> depth_q == '0)
		else $error("frames left open at idle");

	// an error status only comes on the single result of an add
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> lastr_q && !lastc_q)
		else $error("error status on a search result");

endmodule

// ===== rtl/strongly_connected_components.sv =====
// Flow: a clear or rejected add passes through S_EMIT1 to the output register, a stored
// add through S_ADD_WR and S_EMIT1. A search visits each node in S_VIS and S_VIS_HEAD,
// steps each edge in S_STEP and S_EDGE_GOT (and S_DISC_GOT when the target is on the
// stack), emits in S_POP_RD and S_POP_GOT, returns in S_RET and S_RET_GOT. One item at a time.
// Reset: asynchronous, clears control state, empties every edge list and sets
// node_count to 64; no clearing pass, the block takes items right after reset.
// Top level: holds node_count and ties the sequencer to the graph store (scc_pkg).
module strongly_connected_components #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [scc_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [scc_pkg::NODE_W-1:0]   src_node,
	input  logic [scc_pkg::NODE_W-1:0]   dst_node,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [scc_pkg::NODE_W-1:0]   node_id,
	output logic [scc_pkg::COMP_W-1:0]   component_index,
	output logic                         last_of_component,
	output logic                         last_of_run,
	output logic [1:0]                   status
);
	import scc_pkg::*;

	localparam int AW = $clog2(MAX_EDGES);
	localparam int EW = $clog2(MAX_EDGES + 1);

	logic [CNT_W-1:0]  node_count_q, n_active;
	logic              clear_en, head_rd_en, add_en, edge_rd_en, full;
	logic [NODE_W-1:0] head_addr, add_src, add_dst, edge_tgt;
	logic [EW-1:0]     head_ptr, edge_link;
	logic [AW-1:0]     edge_addr;

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= NODE_COUNT_RST;
		else if (cfg_we)
			node_count_q <= cfg_wdata;
	end

	// zero counts as one, above the node limit clamps to it
	always_comb begin
		if (node_count_q == '0)
			n_active = CNT_W'(1);
		else if (node_count_q > CNT_W'(MAX_NODES))
			n_active = CNT_W'(MAX_NODES);
		else
			n_active = node_count_q;
	end

	scc_graph #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_graph (
		.clk, .arst_n, .clear_en, .head_rd_en, .head_addr, .head_ptr,
		.add_en, .add_src, .add_dst, .edge_rd_en, .edge_addr, .edge_tgt,
		.edge_link, .full
	);

	scc_ctrl #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
		.clk, .arst_n, .n_active, .in_valid, .in_ready, .operation, .src_node,
		.dst_node, .out_valid, .out_ready, .node_id, .component_index,
		.last_of_component, .last_of_run, .status, .clear_en, .head_rd_en,
		.head_addr, .head_ptr, .add_en, .add_src, .add_dst, .edge_rd_en,
		.edge_addr, .edge_tgt, .edge_link, .full
	);

endmodule

// ===== test/tb_top.sv =====
// Testbench for strongly_connected_components: directed table, then random graphs and searches.
// Depends on scc_pkg and the RTL top; results are checked against an in-bench Tarjan predictor.
`timescale 1ns / 100ps

module tb_top;
	import scc_pkg::*;

	localparam int NN = 64;
	localparam int NE = 256;
	localparam int NIL = NE;
	localparam logic [1:0] OP_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = OP_ADD;
	logic [NODE_W-1:0] src_node = '0;
	logic [NODE_W-1:0] dst_node = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [NODE_W-1:0] node_id;
	logic [COMP_W-1:0] component_index;
	logic last_of_component;
	logic last_of_run;
	logic [1:0] status;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [COMP_W-1:0] comp;
		logic lastc;
		logic lastr;
		logic [1:0] st;
	} scc_res_t;

	typedef struct {
		logic [1:0] op;
		logic [5:0] src;
		logic [5:0] dst;
		bit known;
		logic [1:0] st;
	} stim_row_t;

	strongly_connected_components i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .src_node(src_node), .dst_node(dst_node),
		.out_valid(out_valid), .out_ready(out_ready),
		.node_id(node_id), .component_index(component_index),
		.last_of_component(last_of_component), .last_of_run(last_of_run),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the graph
	int unsigned pr_count = 64;
	int unsigned pr_head[NN];
	int unsigned pr_target[NE];
	int unsigned pr_link[NE];
	int unsigned pr_edges = 0;
	scc_res_t expected_q[$];
	int mismatches = 0;
	int dir_status_errs = 0;

	function automatic int unsigned nodes_in_use();
		if (pr_count == 0) return 1;
		if (pr_count > NN) return NN;
		return pr_count;
	endfunction

	function automatic void graph_clear();
		for (int i = 0; i < NN; i++) pr_head[i] = NIL;
		pr_edges = 0;
	endfunction

	function automatic scc_res_t one_result(logic [1:0] st);
		scc_res_t r;
		r = '0;
		r.lastr = 1'b1;
		r.st = st;
		return r;
	endfunction

	// Tarjan search with explicit frames; pushes every emitted node
	function automatic void predict_components();
		int unsigned n, depth, top, clk_t, comp, u, cur, v, w, p;
		int unsigned disc[NN], low[NN], stk[NN], fnode[NN], fcur[NN];
		bit onst[NN];
		scc_res_t r;
		int k;
		n = nodes_in_use();
		depth = 0; top = 0; clk_t = 0; comp = 0; k = 0;
		for (int i = 0; i < NN; i++) begin
			disc[i] = 0; low[i] = 0; onst[i] = 0;
		end
		for (int unsigned root = 0; root < n; root++) begin
			if (disc[root] != 0) continue;
			clk_t = (clk_t + 1) & 8'h7F;
			disc[root] = clk_t; low[root] = clk_t;
			stk[top++] = root; onst[root] = 1;
			fnode[depth] = root; fcur[depth] = pr_head[root]; depth++;
			while (depth > 0) begin
				u = fnode[depth-1];
				cur = fcur[depth-1];
				if (cur < NE) begin
					v = pr_target[cur];
					fcur[depth-1] = pr_link[cur];
					if (v >= n) continue;
					if (disc[v] == 0) begin
						clk_t = (clk_t + 1) & 8'h7F;
						disc[v] = clk_t; low[v] = clk_t;
						if (top < NN) stk[top++] = v;
						onst[v] = 1;
						if (depth < NN) begin
							fnode[depth] = v; fcur[depth] = pr_head[v]; depth++;
						end
					end else if (onst[v]) begin
						if (disc[v] < low[u]) low[u] = disc[v];
					end
					continue;
				end
				if (low[u] == disc[u]) begin
					while (top > 0) begin
						w = stk[--top];
						onst[w] = 0;
						r = '0;
						r.node = NODE_W'(w);
						r.comp = COMP_W'(comp);
						r.lastc = (w == u);
						if (k < NN) begin
							expected_q.push_back(r);
							k++;
						end
						if (w == u) break;
					end
					comp = (comp + 1) & 6'h3F;
				end
				depth--;
				if (depth > 0) begin
					p = fnode[depth-1];
					if (low[u] < low[p]) low[p] = low[u];
				end
			end
		end
		if (k > 0) expected_q[$].lastr = 1'b1;
	endfunction

	function automatic logic [1:0] predict_item(logic [1:0] op, int unsigned s, int unsigned d);
		int unsigned n;
		logic [1:0] st;
		n = nodes_in_use();
		st = ST_OK;
		if (op == OP_ADD) begin
			if (s >= n || d >= n) st = ST_RANGE;
			else if (pr_edges >= NE) st = ST_FULL;
			else begin
				pr_target[pr_edges] = d;
				pr_link[pr_edges] = pr_head[s];
				pr_head[s] = pr_edges;
				pr_edges++;
			end
			expected_q.push_back(one_result(st));
		end else if (op == OP_RUN) begin
			predict_components();
		end else if (op == OP_CLEAR) begin
			graph_clear();
			expected_q.push_back(one_result(ST_OK));
		end
		return st;
	endfunction

	// receiver: stall pattern of its own, checks at the rising edge
	int stall_mode = 0;
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		scc_res_t got, exp_r;
		if (arst_n && out_valid && out_ready) begin
			got = '{node_id, component_index, last_of_component, last_of_run, status};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", exp_r, got);
				end
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [5:0] s, logic [5:0] d,
		output logic [1:0] st);
		operation <= op;
		src_node <= s;
		dst_node <= d;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		st = predict_item(op, s, d);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		drop_valid();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_count(logic [6:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		pr_count = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random mix of mostly adds with searches, clears and no-ops, followed by a search; sizes mostly small
	task automatic random_phase(int items);
		int unsigned n, burst;
		logic [1:0] st, op;
		n = nodes_in_use();
		burst = 0;
		for (int i = 0; i < items; i++) begin
			if (burst == 0) begin
				drop_valid();
				repeat ($urandom_range(0, 6)) @(negedge clk);
				burst = $urandom_range(1, 12);
			end
			burst--;
			case ($urandom_range(0, 19))
				0, 1, 2: op = OP_RUN;
				3: op = OP_CLEAR;
				4: op = OP_NOP;
				default: op = OP_ADD;
			endcase
			if ($urandom_range(0, 9) == 0)
				send_item(op, 6'($urandom), 6'($urandom), st);
			else
				send_item(op, 6'($urandom_range(0, n-1)), 6'($urandom_range(0, n-1)), st);
		end
		send_item(OP_RUN, '0, '0, st);
	endtask

	stim_row_t dir_rows[$];

	initial begin
		logic [1:0] st;
		graph_clear();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table at node_count 64 then 4
		dir_rows = '{
			'{OP_RUN, 0, 0, 0, ST_OK},
			'{OP_ADD, 63, 0, 1, ST_OK},
			'{OP_ADD, 0, 63, 1, ST_OK},
			'{OP_ADD, 5, 5, 1, ST_OK},
			'{OP_ADD, 1, 2, 1, ST_OK},
			'{OP_ADD, 2, 1, 1, ST_OK},
			'{OP_RUN, 0, 0, 0, ST_OK},
			'{OP_NOP, 63, 63, 0, ST_OK},
			'{OP_CLEAR, 0, 0, 1, ST_OK},
			'{OP_RUN, 0, 0, 0, ST_OK}
		};
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].src, dir_rows[i].dst, st);
			if (dir_rows[i].known && st !== dir_rows[i].st) dir_status_errs++;
		end
		write_count(7'd4);
		dir_rows = '{
			'{OP_ADD, 4, 0, 1, ST_RANGE},
			'{OP_ADD, 0, 63, 1, ST_RANGE},
			'{OP_ADD, 0, 1, 1, ST_OK},
			'{OP_ADD, 1, 2, 1, ST_OK},
			'{OP_ADD, 2, 0, 1, ST_OK},
			'{OP_ADD, 3, 3, 1, ST_OK},
			'{OP_RUN, 0, 0, 0, ST_OK}
		};
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].src, dir_rows[i].dst, st);
			if (dir_rows[i].known && st !== dir_rows[i].st) dir_status_errs++;
		end
		// count lowered with edges to high nodes still stored
		write_count(7'd2);
		send_item(OP_RUN, '0, '0, st);
		write_count(7'd0);
		send_item(OP_ADD, 0, 0, st);
		send_item(OP_ADD, 0, 1, st);
		send_item(OP_RUN, '0, '0, st);
		write_count(7'd127);
		send_item(OP_RUN, '0, '0, st);

		// fill the edge store past full
		write_count(7'd8);
		send_item(OP_CLEAR, 0, 0, st);
		stall_mode = 0;
		for (int i = 0; i < 258; i++)
			send_item(OP_ADD, 6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)), st);
		if (st !== ST_FULL) dir_status_errs++;
		send_item(OP_RUN, '0, '0, st);
		send_item(OP_CLEAR, 0, 0, st);

		// random phases across settings, receiver pattern varies
		stall_mode = 1;
		write_count(7'd6);
		random_phase(20);
		stall_mode = 2;
		write_count(7'd1);
		random_phase(8);
		stall_mode = 0;
		write_count(7'd16);
		send_item(OP_CLEAR, 0, 0, st);
		random_phase(15);
		stall_mode = 1;
		write_count(7'd64);
		send_item(OP_CLEAR, 0, 0, st);
		random_phase(20);

		wait_drained();
		if (mismatches == 0 && dir_status_errs == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== strongly_connected_components.f =====
rtl/scc_pkg.sv
rtl/scc_graph.sv
rtl/scc_ctrl.sv
rtl/strongly_connected_components.sv
test/tb_top.sv
